[rtl/core/assert_macros.svh]
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HFA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HFA_ASSERT(label, clk, rst_n, prop, msg)
`define HFA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/core/hfa_pkg.sv]
package hfa_pkg;

    localparam int HEAP_WORDS_DEF = 512;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int OFFSET_W  = 13;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // header status codes
    localparam logic [1:0] HS_NEW   = 2'd0;
    localparam logic [1:0] HS_USED  = 2'd1;
    localparam logic [1:0] HS_FREED = 2'd2;

    typedef enum logic [2:0] {
        RS_OK            = 3'd0,
        RS_ZERO_SIZE     = 3'd1,
        RS_TOO_LARGE     = 3'd2,
        RS_NO_SPACE      = 3'd3,
        RS_OUT_OF_BOUNDS = 3'd4,
        RS_NOTHING_ALLOC = 3'd5,
        RS_DOUBLE_FREE   = 3'd6,
        RS_BAD_PTR       = 3'd7
    } res_status_t;

    typedef struct packed {
        res_status_t           status;
        logic [OFFSET_W-1:0]   payload_offset;
        logic                  heap_leaky;
    } res_t;

endpackage

[rtl/core/first_fit_heap_allocator_unit.sv]
// first-fit heap allocator over an implicit list of 8-byte block headers
// input beats (s_*): s_tuser picks allocate (0) or free (1), s_tdata carries
// the request size and the payload offset to free
// output beats (m_*): one result beat per input beat, in order, with status,
// allocated payload offset and the heap_leaky flag
// an item is worked in steps: the request check, then a walk that reads one header
// at a time; a successful free also reads the block after the target before its
// write, and a block that is split or merged backward takes a second header write;
// the walk is serial because the header memory has a single read port and each
// next header address comes from the size just read
// the result beat shows on m_tvalid in the same cycle s_tready comes back
// one item is worked at a time; s_tready is high only while the walker is idle,
// and a new item is taken while an earlier result still waits in the output
// register
// reset returns the walker to idle and marks the heap empty; header 0 is kept
// in flops so no clearing pass over the header memory is needed
// when m_tready is low and the output register is full, the finished result parks
// in the walker until the output register drains, and no further input is taken
module first_fit_heap_allocator_unit #(
    parameter int HEAP_WORDS = hfa_pkg::HEAP_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hfa_pkg::S_TDATA_W-1:0] s_tdata,  // request_size, block_offset
    input  logic                          s_tuser,  // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hfa_pkg::M_TDATA_W-1:0] m_tdata   // status, payload_offset, heap_leaky, zero pad
);

    import hfa_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int HW = AW + 2;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic [HW-1:0] hdr0;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [HW-1:0] rd_hdr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [HW-1:0] wr_hdr;

    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    hfa_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .cmd          (s_tuser),
        .request_size (s_tdata[15:0]),
        .block_offset (s_tdata[31:16]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .hdr0         (hdr0),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_hdr       (rd_hdr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_hdr       (wr_hdr)
    );

    hfa_hdr_store #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_hdr  (wr_hdr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_hdr  (rd_hdr),
        .hdr0    (hdr0)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.heap_leaky, out_reg.payload_offset, out_reg.status};

endmodule

[rtl/core/hfa_hdr_store.sv]
module hfa_hdr_store #(
    parameter int HEAP_WORDS = hfa_pkg::HEAP_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS),
    localparam int HW = AW + 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [HW-1:0] wr_hdr,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [HW-1:0] rd_hdr,
    output logic [HW-1:0] hdr0
);

    logic [HW-1:0] mem [HEAP_WORDS];
    logic [HW-1:0] mem_q_reg;
    logic [HW-1:0] hdr0_reg;
    logic          sel0_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_hdr;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // header 0 lives in flops so it reads as zero until the first allocate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr0_reg <= '0;
            sel0_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr == '0))
            begin
                hdr0_reg <= wr_hdr;
            end
            if (rd_en)
            begin
                sel0_reg <= (rd_addr == '0);
            end
        end
    end

    assign rd_hdr = sel0_reg ? hdr0_reg : mem_q_reg;
    assign hdr0   = hdr0_reg;

endmodule

[rtl/core/hfa_ctrl.sv]
`include "assert_macros.svh"

module hfa_ctrl #(
    parameter int HEAP_WORDS = hfa_pkg::HEAP_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS),
    localparam int HW = AW + 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          cmd,
    input  logic [15:0]   request_size,
    input  logic [15:0]   block_offset,
    output logic          res_valid,
    input  logic          res_ready,
    output hfa_pkg::res_t res,
    input  logic [HW-1:0] hdr0,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [HW-1:0] rd_hdr,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [HW-1:0] wr_hdr
);

    import hfa_pkg::*;

    localparam int AW1   = AW + 1;
    localparam int AW2   = AW + 2;
    localparam int PAY_W = (AW + 3 > OFFSET_W) ? AW + 3 : OFFSET_W;

    localparam logic [16:0]   HEAP_BYTES = 17'(HEAP_WORDS * 8);
    localparam logic [16:0]   REQ_MAX    = 17'(HEAP_WORDS * 8 - 8);
    localparam logic [AW1-1:0] WORDS_W   = AW1'(HEAP_WORDS);
    localparam logic [AW1-1:0] LAST_PAY  = AW1'(HEAP_WORDS - 1);
    localparam logic [AW-1:0]  LAST_H    = AW'(HEAP_WORDS - 1);
    localparam logic [AW-1:0]  SZ_FULL   = AW'(HEAP_WORDS - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_AWALK = 8'b0000_0100,
        ST_FWALK = 8'b0000_1000,
        ST_FTGT  = 8'b0001_0000,
        ST_FFUT  = 8'b0010_0000,
        ST_WR2   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic          cmd_reg, cmd_next;
    logic [15:0]   req_reg, req_next;
    logic [15:0]   ptr_reg, ptr_next;
    logic [AW-1:0] size_reg, size_next;
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] th_reg, th_next;
    logic [AW-1:0] temp_h_reg, temp_h_next;
    logic [AW-1:0] temp_sz_reg, temp_sz_next;
    logic [1:0]    temp_st_reg, temp_st_next;
    logic          have_temp_reg, have_temp_next;
    logic [AW-1:0] ptr_sz_reg, ptr_sz_next;
    logic          fut_ok_reg, fut_ok_next;
    logic [AW-1:0] wr2_addr_reg, wr2_addr_next;
    logic [HW-1:0] wr2_hdr_reg, wr2_hdr_next;
    res_status_t   status_reg, status_next;
    logic [AW-1:0] where_reg, where_next;

    logic [AW-1:0]  rd_sz;
    logic [1:0]     rd_st;
    logic           rd_free;
    logic [AW-1:0]  h0_sz;
    logic [1:0]     h0_st;
    logic [16:0]    req_up;
    logic [AW-1:0]  size_w;
    logic [AW1-1:0] nh;
    logic [AW1-1:0] fut;
    logic [AW-1:0]  th_calc;
    logic           temp_free;
    logic           fut_free;
    logic [PAY_W-1:0] off_wide;

    assign rd_sz   = rd_hdr[AW-1:0];
    assign rd_st   = rd_hdr[AW+1:AW];
    assign rd_free = (rd_st == HS_NEW) || (rd_st == HS_FREED);
    assign h0_sz   = hdr0[AW-1:0];
    assign h0_st   = hdr0[AW+1:AW];

    assign req_up  = {1'b0, req_reg} + 17'd7;
    assign size_w  = AW'(req_up >> 3);
    assign nh      = AW1'(h_reg) + AW1'(rd_sz) + AW1'(1);
    assign fut     = AW1'(th_reg) + AW1'(rd_sz) + AW1'(1);
    assign th_calc = AW'(ptr_reg[15:3] - 13'd1);

    assign temp_free = have_temp_reg && ((temp_st_reg == HS_NEW) || (temp_st_reg == HS_FREED));
    assign fut_free  = fut_ok_reg && rd_free;

    assign off_wide = PAY_W'({where_reg, 3'b000});

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.status         = status_reg;
        res.payload_offset = off_wide[OFFSET_W-1:0];
        res.heap_leaky     = !(((h0_st == HS_NEW) || (h0_st == HS_FREED)) && (h0_sz == SZ_FULL));
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        req_next       = req_reg;
        ptr_next       = ptr_reg;
        size_next      = size_reg;
        h_next         = h_reg;
        th_next        = th_reg;
        temp_h_next    = temp_h_reg;
        temp_sz_next   = temp_sz_reg;
        temp_st_next   = temp_st_reg;
        have_temp_next = have_temp_reg;
        ptr_sz_next    = ptr_sz_reg;
        fut_ok_next    = fut_ok_reg;
        wr2_addr_next  = wr2_addr_reg;
        wr2_hdr_next   = wr2_hdr_reg;
        status_next    = status_reg;
        where_next     = where_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_hdr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd_next   = cmd;
                    req_next   = request_size;
                    ptr_next   = block_offset;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                where_next     = '0;
                have_temp_next = 1'b0;
                size_next      = size_w;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (req_reg == 16'd0)
                    begin
                        status_next = RS_ZERO_SIZE;
                        state_next  = ST_DONE;
                    end
                    else if ({1'b0, req_reg} > REQ_MAX)
                    begin
                        status_next = RS_TOO_LARGE;
                        state_next  = ST_DONE;
                    end
                    else if (h0_st == HS_NEW)
                    begin
                        // first allocate: carve the front, rest, if any, becomes one new block
                        wr_en       = 1'b1;
                        wr_addr     = '0;
                        wr_hdr      = {HS_USED, size_w};
                        where_next  = AW'(1);
                        status_next = RS_OK;
                        if ((AW1'(size_w) + AW1'(1)) < WORDS_W)
                        begin
                            wr2_addr_next = AW'(AW1'(size_w) + AW1'(1));
                            wr2_hdr_next  = {HS_NEW, AW'(WORDS_W - AW1'(size_w) - AW1'(2))};
                            state_next    = ST_WR2;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        h_next     = '0;
                        state_next = ST_AWALK;
                    end
                end
                else
                begin
                    if ({1'b0, ptr_reg} > HEAP_BYTES)
                    begin
                        status_next = RS_OUT_OF_BOUNDS;
                        state_next  = ST_DONE;
                    end
                    else if ((h0_st == HS_NEW) && (h0_sz == '0))
                    begin
                        status_next = RS_NOTHING_ALLOC;
                        state_next  = ST_DONE;
                    end
                    else if ((ptr_reg[2:0] != 3'd0) || (ptr_reg[15:3] == 13'd0))
                    begin
                        status_next = RS_BAD_PTR;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        h_next  = '0;
                        th_next = th_calc;
                        if (th_calc == '0)
                        begin
                            state_next = ST_FTGT;
                        end
                        else
                        begin
                            state_next = ST_FWALK;
                        end
                    end
                end
            end

            ST_AWALK:
            begin
                if (rd_free && (rd_sz > size_reg))
                begin
                    wr_en         = 1'b1;
                    wr_addr       = h_reg;
                    wr_hdr        = {HS_USED, size_reg};
                    wr2_addr_next = AW'(AW1'(h_reg) + AW1'(size_reg) + AW1'(1));
                    wr2_hdr_next  = {HS_NEW, AW'(rd_sz - size_reg - AW'(1))};
                    where_next    = AW'(AW1'(h_reg) + AW1'(1));
                    status_next   = RS_OK;
                    state_next    = ST_WR2;
                end
                else if (rd_free && (rd_sz == size_reg))
                begin
                    wr_en       = 1'b1;
                    wr_addr     = h_reg;
                    wr_hdr      = {HS_USED, size_reg};
                    where_next  = AW'(AW1'(h_reg) + AW1'(1));
                    status_next = RS_OK;
                    state_next  = ST_DONE;
                end
                else if ((rd_st == HS_USED) || (rd_sz < size_reg))
                begin
                    // next header address comes straight from the size just read
                    if (nh < LAST_PAY)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(nh);
                        h_next  = AW'(nh);
                    end
                    else
                    begin
                        status_next = RS_NO_SPACE;
                        state_next  = ST_DONE;
                    end
                end
                else
                begin
                    status_next = RS_NO_SPACE;
                    state_next  = ST_DONE;
                end
            end

            ST_FWALK:
            begin
                temp_h_next    = h_reg;
                temp_sz_next   = rd_sz;
                temp_st_next   = rd_st;
                have_temp_next = 1'b1;
                if (nh < AW1'(th_reg))
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(nh);
                    h_next  = AW'(nh);
                end
                else if (nh == AW1'(th_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = th_reg;
                    state_next = ST_FTGT;
                end
                else
                begin
                    status_next = RS_BAD_PTR;
                    state_next  = ST_DONE;
                end
            end

            ST_FTGT:
            begin
                if (rd_st == HS_FREED)
                begin
                    status_next = RS_DOUBLE_FREE;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ptr_sz_next = rd_sz;
                    fut_ok_next = (fut < LAST_PAY);
                    if (fut < LAST_PAY)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(fut);
                    end
                    state_next = ST_FFUT;
                end
            end

            ST_FFUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = th_reg;
                wr_hdr      = {HS_FREED, ptr_sz_reg};
                status_next = RS_OK;
                state_next  = ST_DONE;
                if (temp_free)
                begin
                    // merge into the block before, a free block after folds in too
                    wr2_addr_next = temp_h_reg;
                    if (fut_free)
                    begin
                        wr2_hdr_next = {temp_st_reg, AW'(AW2'(temp_sz_reg) + AW2'(2)
                                        + AW2'(ptr_sz_reg) + AW2'(rd_sz))};
                    end
                    else
                    begin
                        wr2_hdr_next = {temp_st_reg, AW'(AW2'(temp_sz_reg) + AW2'(1)
                                        + AW2'(ptr_sz_reg))};
                    end
                    state_next = ST_WR2;
                end
                else if (fut_free)
                begin
                    wr_hdr = {HS_FREED, AW'(AW2'(ptr_sz_reg) + AW2'(1) + AW2'(rd_sz))};
                end
            end

            ST_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = wr2_addr_reg;
                wr_hdr     = wr2_hdr_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_temp_reg <= 1'b0;
            fut_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_temp_reg <= have_temp_next;
            fut_ok_reg    <= fut_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        size_reg     <= size_next;
        h_reg        <= h_next;
        th_reg       <= th_next;
        temp_h_reg   <= temp_h_next;
        temp_sz_reg  <= temp_sz_next;
        temp_st_reg  <= temp_st_next;
        ptr_sz_reg   <= ptr_sz_next;
        wr2_addr_reg <= wr2_addr_next;
        wr2_hdr_reg  <= wr2_hdr_next;
        status_reg   <= status_next;
        where_reg    <= where_next;
    end

    `HFA_ASSERT_NR(a_rd_wr_apart, clk, $onehot0({wr_en, rd_en}), "header read and write collide")
    `HFA_ASSERT(a_idle_quiet, clk, rst_n, (state_reg == ST_IDLE) |-> (!wr_en && !rd_en), "store access while idle")
    `HFA_ASSERT(a_awalk_in_heap, clk, rst_n, (state_reg == ST_AWALK) |-> (h_reg < LAST_H), "allocate walk past heap end")
    `HFA_ASSERT(a_fwalk_below_tgt, clk, rst_n, (state_reg == ST_FWALK) |-> (h_reg < th_reg), "free walk past target")
    `HFA_ASSERT(a_done_to_idle, clk, rst_n, (res_valid && res_ready) |=> (state_reg == ST_IDLE), "result handoff did not return to idle")

endmodule
